// File: sv/wavhp_pkg.sv
// Shared types, codes and constants for the RIFF/WAVE header parser.
package wavhp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [2:0] ST_HEADER  = 3'd0;
   localparam logic [2:0] ST_ACCEPT  = 3'd1;
   localparam logic [2:0] ST_PAYLOAD = 3'd2;
   localparam logic [2:0] ST_ERROR   = 3'd3;
   localparam logic [2:0] ST_IGNORE  = 3'd4;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_RIFF   = 3'd1;
   localparam logic [2:0] ERR_NO_WAVE   = 3'd2;
   localparam logic [2:0] ERR_FMT_TAG   = 3'd3;
   localparam logic [2:0] ERR_BITS      = 3'd4;
   localparam logic [2:0] ERR_DATA_SIZE = 3'd5;
   localparam logic [2:0] ERR_EARLY_END = 3'd6;

   localparam logic [1:0] FMT_U8  = 2'd0;
   localparam logic [1:0] FMT_S16 = 2'd1;
   localparam logic [1:0] FMT_S32 = 2'd2;
   localparam logic [1:0] FMT_F32 = 2'd3;

   localparam logic [15:0] FTAG_PCM   = 16'd1;
   localparam logic [15:0] FTAG_FLOAT = 16'd3;
   localparam logic [15:0] BITS_8     = 16'd8;
   localparam logic [15:0] BITS_16    = 16'd16;
   localparam logic [15:0] BITS_32    = 16'd32;
   localparam logic [31:0] FMT_FIXED_LEN = 32'd16;

   localparam int DIV_STEPS = 32;

   typedef enum logic [16:0] {
      PH_RIFF  = 17'h00001,
      PH_RSIZE = 17'h00002,
      PH_WAVE  = 17'h00004,
      PH_FID   = 17'h00008,
      PH_FSIZE = 17'h00010,
      PH_FSKIP = 17'h00020,
      PH_FTAG  = 17'h00040,
      PH_CHAN  = 17'h00080,
      PH_RATE  = 17'h00100,
      PH_BITS  = 17'h00200,
      PH_FREST = 17'h00400,
      PH_DID   = 17'h00800,
      PH_DSIZE = 17'h01000,
      PH_DSKIP = 17'h02000,
      PH_DATA  = 17'h04000,
      PH_IDLE  = 17'h08000,
      PH_DIV   = 17'h10000
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_first;
      logic       in_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  error_code;
      logic [7:0]  out_byte;
      logic        out_last;
      logic [1:0]  sample_format;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] frame_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       step;
      logic       first;
      logic [2:0] idx;
      logic       tag_shift;
      logic       tag_load;
      logic       chunk_wr;
      logic       skip_chunk;
      logic       skip_rest;
      logic       skip_dec;
      logic       float_wr;
      logic       float_val;
      logic       chan_wr;
      logic       rate_wr;
      logic       bits_wr;
      logic       pay_load;
      logic       pay_dec;
      logic       div_start;
      logic       div_ok;
      logic       err_wr;
      logic [2:0] err_code;
      logic       out_wr;
      logic [2:0] out_status;
      logic       out_pass;
      logic       out_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tag_riff;
      logic tag_wave;
      logic tag_fmt;
      logic tag_data;
      logic chunk_zero;
      logic chunk_gt16;
      logic skip_last;
      logic pay_last;
      logic ftag_pcm;
      logic ftag_float;
      logic bits8;
      logic bits16;
      logic bits32;
      logic is_float;
      logic frame_zero;
      logic div_done;
      logic div_exact;
   } flag_type;

endpackage

// File: sv/wavhp_div.sv
// Restoring divider, one quotient bit per cycle, for the frame count.
module wavhp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [17:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic        exact
);
   import wavhp_pkg::*;

   logic [31:0] q_ff, q_in;
   logic [17:0] r_ff, r_in;
   logic [17:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [18:0] trial;
   logic [18:0] diff;

   always_comb begin
      trial   = {r_ff, q_ff[31]};
      diff    = trial - {1'b0, d_ff};
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = 6'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = diff[17:0];
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = trial[17:0];
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
   assign exact    = (r_ff == '0);

endmodule

// File: sv/wavhp_dp.sv
// Datapath: header fields, counters, divider and the result register.
module wavhp_dp (
   input  logic                clock,
   input  logic                reset,
   input  wavhp_pkg::req_type  req,
   input  wavhp_pkg::cmd_type  cmd,
   output wavhp_pkg::flag_type flags,
   output wavhp_pkg::rsp_type  rsp
);
   import wavhp_pkg::*;

   logic [31:0] tag_ff, tag_in, tag_cur, tag_next;
   logic [31:0] chunk_ff, chunk_in, chunk_cur, chunk_next;
   logic [31:0] skip_ff, skip_in, skip_cur;
   logic        float_ff, float_in, float_cur;
   logic [15:0] chan_ff, chan_in, chan_cur;
   logic [31:0] rate_ff, rate_in, rate_cur;
   logic [1:0]  fmt_ff, fmt_in, fmt_cur;
   logic [17:0] frame_ff, frame_in, frame_cur;
   logic [31:0] frames_ff, frames_in, frames_cur;
   logic [31:0] pay_ff, pay_in, pay_cur;
   logic [2:0]  err_ff, err_in, err_cur;
   rsp_type     rsp_ff, rsp_in;
   logic        clr;
   logic [7:0]  b;
   logic [4:0]  sh;
   logic [15:0] word;
   logic [1:0]  bps_shift;
   logic [1:0]  fmt_new;
   logic        div_done;
   logic [31:0] div_q;
   logic        div_exact;

   wavhp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (chunk_next),
      .divisor  (frame_cur),
      .done     (div_done),
      .quotient (div_q),
      .exact    (div_exact)
   );

   always_comb begin
      clr  = cmd.step && cmd.first;
      b    = req.in_byte;
      sh   = {cmd.idx[1:0], 3'b000};
      tag_cur    = clr ? '0 : tag_ff;
      chunk_cur  = clr ? '0 : chunk_ff;
      skip_cur   = clr ? '0 : skip_ff;
      float_cur  = clr ? 1'b0 : float_ff;
      chan_cur   = clr ? '0 : chan_ff;
      rate_cur   = clr ? '0 : rate_ff;
      fmt_cur    = clr ? '0 : fmt_ff;
      frame_cur  = clr ? '0 : frame_ff;
      frames_cur = clr ? '0 : frames_ff;
      pay_cur    = clr ? '0 : pay_ff;
      err_cur    = clr ? '0 : err_ff;

      tag_next   = {tag_cur[23:0], b};
      chunk_next = (cmd.idx == 3'd0) ? {24'd0, b} : (chunk_cur | ({24'd0, b} << sh));
      word       = {b, tag_cur[7:0]};

      if (word == BITS_8) begin
         fmt_new = FMT_U8;  bps_shift = 2'd0;
      end else if (word == BITS_16) begin
         fmt_new = FMT_S16; bps_shift = 2'd1;
      end else begin
         fmt_new = float_cur ? FMT_F32 : FMT_S32; bps_shift = 2'd2;
      end

      tag_in = tag_cur;
      if (cmd.tag_shift)     tag_in = tag_next;
      else if (cmd.tag_load) tag_in = {24'd0, b};
      chunk_in = cmd.chunk_wr ? chunk_next : chunk_cur;
      skip_in  = skip_cur;
      if (cmd.skip_chunk)     skip_in = chunk_next;
      else if (cmd.skip_rest) skip_in = chunk_cur - FMT_FIXED_LEN;
      else if (cmd.skip_dec)  skip_in = skip_cur - 32'd1;
      float_in = cmd.float_wr ? cmd.float_val : float_cur;
      chan_in  = chan_cur;
      if (cmd.chan_wr)
         chan_in = (cmd.idx == 3'd0) ? {8'd0, b} : {b, chan_cur[7:0]};
      rate_in = rate_cur;
      if (cmd.rate_wr)
         rate_in = (cmd.idx == 3'd0) ? {24'd0, b} : (rate_cur | ({24'd0, b} << sh));
      fmt_in   = cmd.bits_wr ? fmt_new : fmt_cur;
      frame_in = cmd.bits_wr ? ({2'd0, chan_cur} << bps_shift) : frame_cur;
      frames_in = cmd.div_ok ? div_q : frames_cur;
      pay_in = pay_cur;
      if (cmd.pay_load)     pay_in = chunk_cur;
      else if (cmd.pay_dec) pay_in = pay_cur - 32'd1;
      err_in = cmd.err_wr ? cmd.err_code : err_cur;

      rsp_in = rsp_ff;
      if (cmd.out_wr) begin
         rsp_in.status        = cmd.out_status;
         rsp_in.error_code    = err_in;
         rsp_in.out_byte      = cmd.out_pass ? b : 8'd0;
         rsp_in.out_last      = cmd.out_last;
         rsp_in.sample_format = fmt_in;
         rsp_in.channel_count = chan_in;
         rsp_in.sample_rate   = rate_in;
         rsp_in.frame_count   = frames_in;
      end

      flags.tag_riff   = (tag_next == TAG_RIFF);
      flags.tag_wave   = (tag_next == TAG_WAVE);
      flags.tag_fmt    = (tag_cur == TAG_FMT);
      flags.tag_data   = (tag_cur == TAG_DATA);
      flags.chunk_zero = (chunk_next == '0);
      flags.chunk_gt16 = (chunk_cur > FMT_FIXED_LEN);
      flags.skip_last  = (skip_cur == 32'd1);
      flags.pay_last   = (pay_cur == 32'd1);
      flags.ftag_pcm   = (word == FTAG_PCM);
      flags.ftag_float = (word == FTAG_FLOAT);
      flags.bits8      = (word == BITS_8);
      flags.bits16     = (word == BITS_16);
      flags.bits32     = (word == BITS_32);
      flags.is_float   = float_cur;
      flags.frame_zero = (frame_cur == '0);
      flags.div_done   = div_done;
      flags.div_exact  = div_exact;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         tag_ff    <= '0;
         chunk_ff  <= '0;
         skip_ff   <= '0;
         float_ff  <= 1'b0;
         chan_ff   <= '0;
         rate_ff   <= '0;
         fmt_ff    <= '0;
         frame_ff  <= '0;
         frames_ff <= '0;
         pay_ff    <= '0;
         err_ff    <= '0;
      end else begin
         tag_ff    <= tag_in;
         chunk_ff  <= chunk_in;
         skip_ff   <= skip_in;
         float_ff  <= float_in;
         chan_ff   <= chan_in;
         rate_ff   <= rate_in;
         fmt_ff    <= fmt_in;
         frame_ff  <= frame_in;
         frames_ff <= frames_in;
         pay_ff    <= pay_in;
         err_ff    <= err_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// File: sv/wavhp_ctrl.sv
// Controller: parse phase sequencer and request/response handshake.
module wavhp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wavhp_pkg::req_type  req,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  wavhp_pkg::flag_type flags,
   output wavhp_pkg::cmd_type  cmd
);
   import wavhp_pkg::*;

   phase_type  phase_ff, phase_in, ph;
   logic [2:0] idx_ff, idx_in, idx;
   logic       valid_ff, valid_in;
   logic       end_ff, end_in;
   logic       step;
   logic       fail;
   logic [2:0] fail_code;
   logic [2:0] status;

   assign req_stall = (phase_ff == PH_DIV) || (valid_ff && rsp_stall);
   assign step      = req_valid && !req_stall;

   always_comb begin
      cmd       = '0;
      cmd.step  = step;
      cmd.first = req.in_first;
      ph        = req.in_first ? PH_RIFF : phase_ff;
      idx       = req.in_first ? 3'd0 : idx_ff;
      cmd.idx   = idx;
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      fail      = 1'b0;
      fail_code = ERR_NONE;
      status    = ST_HEADER;

      if (phase_ff == PH_DIV) begin
         cmd.step = 1'b0;
         if (flags.div_done) begin
            cmd.out_wr = 1'b1;
            idx_in     = 3'd0;
            if (!flags.div_exact) begin
               fail = 1'b1; fail_code = ERR_DATA_SIZE;
            end else begin
               cmd.div_ok   = 1'b1;
               cmd.pay_load = 1'b1;
               if (end_ff) begin
                  fail = 1'b1; fail_code = ERR_EARLY_END;
               end else begin
                  status   = ST_ACCEPT;
                  phase_in = PH_DATA;
               end
            end
            if (fail) begin
               status   = ST_ERROR;
               phase_in = PH_IDLE;
            end
            cmd.err_wr     = fail;
            cmd.err_code   = fail_code;
            cmd.out_status = status;
         end
      end else if (step) begin
         cmd.out_wr = 1'b1;
         phase_in   = ph;
         idx_in     = idx + 3'd1;
         unique case (ph)
            PH_RIFF, PH_WAVE, PH_FID, PH_DID: begin
               cmd.tag_shift = 1'b1;
               if (idx == 3'd3) begin
                  idx_in = 3'd0;
                  if (ph == PH_RIFF) begin
                     if (flags.tag_riff) phase_in = PH_RSIZE;
                     else begin fail = 1'b1; fail_code = ERR_NO_RIFF; end
                  end else if (ph == PH_WAVE) begin
                     if (flags.tag_wave) phase_in = PH_FID;
                     else begin fail = 1'b1; fail_code = ERR_NO_WAVE; end
                  end else begin
                     phase_in = (ph == PH_FID) ? PH_FSIZE : PH_DSIZE;
                  end
               end
            end
            PH_RSIZE, PH_FSIZE, PH_DSIZE: begin
               cmd.chunk_wr = 1'b1;
               if (idx == 3'd3) begin
                  idx_in = 3'd0;
                  if (ph == PH_RSIZE) begin
                     phase_in = PH_WAVE;
                  end else if (ph == PH_FSIZE) begin
                     if (flags.tag_fmt) phase_in = PH_FTAG;
                     else begin
                        cmd.skip_chunk = 1'b1;
                        phase_in = flags.chunk_zero ? PH_FID : PH_FSKIP;
                     end
                  end else if (!flags.tag_data) begin
                     cmd.skip_chunk = 1'b1;
                     phase_in = flags.chunk_zero ? PH_DID : PH_DSKIP;
                  end else if (flags.chunk_zero || flags.frame_zero) begin
                     fail = 1'b1; fail_code = ERR_DATA_SIZE;
                  end else begin
                     // result follows when the frame count is known
                     cmd.div_start = 1'b1;
                     cmd.out_wr    = 1'b0;
                     end_in        = req.in_end;
                     phase_in      = PH_DIV;
                  end
               end
            end
            PH_FSKIP, PH_FREST, PH_DSKIP: begin
               cmd.skip_dec = 1'b1;
               if (flags.skip_last) begin
                  idx_in   = 3'd0;
                  phase_in = (ph == PH_FSKIP) ? PH_FID : PH_DID;
               end
            end
            PH_FTAG: begin
               if (idx == 3'd0) cmd.tag_load = 1'b1;
               else if (flags.ftag_pcm || flags.ftag_float) begin
                  cmd.float_wr  = 1'b1;
                  cmd.float_val = flags.ftag_float;
                  idx_in        = 3'd0;
                  phase_in      = PH_CHAN;
               end else begin
                  fail = 1'b1; fail_code = ERR_FMT_TAG;
               end
            end
            PH_CHAN: begin
               cmd.chan_wr = 1'b1;
               if (idx != 3'd0) begin
                  idx_in = 3'd0; phase_in = PH_RATE;
               end
            end
            PH_RATE: begin
               cmd.rate_wr = 1'b1;
               if (idx == 3'd3) begin
                  idx_in = 3'd0; phase_in = PH_BITS;
               end
            end
            PH_BITS: begin
               if (idx == 3'd6) cmd.tag_load = 1'b1;
               else if (idx == 3'd7) begin
                  if (((flags.bits8 || flags.bits16) && !flags.is_float) || flags.bits32) begin
                     cmd.bits_wr   = 1'b1;
                     cmd.skip_rest = 1'b1;
                     idx_in        = 3'd0;
                     phase_in      = flags.chunk_gt16 ? PH_FREST : PH_DID;
                  end else begin
                     fail = 1'b1; fail_code = ERR_BITS;
                  end
               end
            end
            PH_DATA: begin
               status       = ST_PAYLOAD;
               cmd.out_pass = 1'b1;
               cmd.pay_dec  = 1'b1;
               if (flags.pay_last) begin
                  cmd.out_last = 1'b1;
                  idx_in       = 3'd0;
                  phase_in     = PH_IDLE;
               end
            end
            default: status = ST_IGNORE;
         endcase

         // stream ran out before the parse finished
         if (req.in_end && !fail && phase_in != PH_IDLE && phase_in != PH_DIV) begin
            fail         = 1'b1;
            fail_code    = ERR_EARLY_END;
            cmd.out_pass = 1'b0;
            cmd.out_last = 1'b0;
         end
         if (fail) begin
            status   = ST_ERROR;
            idx_in   = 3'd0;
            phase_in = PH_IDLE;
         end
         cmd.err_wr     = fail;
         cmd.err_code   = fail_code;
         cmd.out_status = status;
      end

      valid_in = valid_ff;
      if (cmd.out_wr) valid_in = 1'b1;
      else if (valid_ff && !rsp_stall) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      end_ff <= end_in;
      if (reset) begin
         phase_ff <= PH_RIFF;
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

// File: sv/riff_wave_header_parser.sv
// RIFF/WAVE header parser: checks the header of a WAV byte stream, reads the
// PCM or float format fields and the frame count, then passes payload bytes
// through; every request gives exactly one response. One request is taken
// per cycle while rsp_stall is low, with the response register decoupling
// the two sides. One more exception is the request that completes the data
// chunk size: the frame count comes from a one-bit-per-cycle divider, so
// that request holds the input stalled until the division is done and its response is written.
module riff_wave_header_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  wavhp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wavhp_pkg::rsp_type rsp_data
);
   import wavhp_pkg::*;

   cmd_type  cmd;
   flag_type flags;

   wavhp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   wavhp_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .flags (flags),
      .rsp   (rsp_data)
   );

endmodule
